### rtl/core/round_robin_scheduler_with_sleep_macros.svh
// ----------------------------------------------------------------------------
// Round-robin scheduler assertion macros
// Shorthand for clocked implication checks used by the checker.
// ----------------------------------------------------------------------------
`ifndef ROUND_ROBIN_SCHEDULER_WITH_SLEEP_MACROS_SVH
`define ROUND_ROBIN_SCHEDULER_WITH_SLEEP_MACROS_SVH

// same-cycle implication
`define RRS_ASSERT_IMP(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (b)) \
		else $error("rrs check failed");

// next-cycle implication
`define RRS_ASSERT_NXT(lbl, a, b) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (b)) \
		else $error("rrs check failed");

`endif

### rtl/core/rrs_pkg.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler package
// Shared codes, constants and control structs.
// ----------------------------------------------------------------------------
package rrs_pkg;

	localparam int MAX_TASKS_DEF = 16;
	localparam int TICK_W        = 27;

	localparam logic [15:0] QUANTUM_RST = 16'd10;
	localparam logic [9:0]  TPS_RST     = 10'd100;

	localparam logic [1:0] REQ_TICK   = 2'd0;
	localparam logic [1:0] REQ_CREATE = 2'd1;
	localparam logic [1:0] REQ_TERM   = 2'd2;
	localparam logic [1:0] REQ_SLEEP  = 2'd3;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_NOFREE = 2'd1;
	localparam logic [1:0] ST_NORUN  = 2'd2;

	localparam logic REG_QUANTUM = 1'b0;
	localparam logic REG_TPS     = 1'b1;

	typedef struct packed {
		logic scan_start;
		logic scan_step;
		logic claim;
		logic release_slot;
	} slot_cmd_t;

	typedef struct packed {
		logic hit;
		logic last;
	} slot_stat_t;

endpackage

### rtl/core/rrs_slots.sv
// ----------------------------------------------------------------------------
// Slot table
// Used bits with a one-slot-per-cycle free-slot scan.
// ----------------------------------------------------------------------------
module rrs_slots #(
	parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEF,
	parameter int IDW       = $clog2(MAX_TASKS)
) (
	input  logic               clk,
	input  logic               arst_n,
	input  rrs_pkg::slot_cmd_t cmd,
	input  logic [IDW-1:0]     rel_id,
	output rrs_pkg::slot_stat_t stat,
	output logic [IDW-1:0]     idx
);
	import rrs_pkg::*;

	logic [MAX_TASKS-1:0] used_q;
	logic [IDW-1:0]       idx_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
			idx_q  <= '0;
		end else begin
			if (cmd.scan_start)
				idx_q <= '0;
			else if (cmd.scan_step)
				idx_q <= idx_q + 1'b1;
			if (cmd.claim)
				used_q[idx_q] <= 1'b1;
			if (cmd.release_slot)
				used_q[rel_id] <= 1'b0;
		end
	end

	assign stat.hit  = !used_q[idx_q];
	assign stat.last = (idx_q == IDW'(MAX_TASKS - 1));
	assign idx       = idx_q;

endmodule

### rtl/core/rrs_seq.sv
// ----------------------------------------------------------------------------
// Scheduler sequencer
// Ready ring, sleeper list and the control that walks them per request.
// ----------------------------------------------------------------------------
module rrs_seq #(
	parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEF,
	parameter int IDW       = $clog2(MAX_TASKS),
	parameter int CW        = $clog2(MAX_TASKS + 1)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          req_type,
	input  logic [15:0]         sleep_seconds,
	input  logic [15:0]         quantum_ticks,
	input  logic [9:0]          ticks_per_second,
	output logic                busy,
	output logic                done,
	output logic [1:0]          status,
	output logic [3:0]          new_id,
	output logic                current_valid,
	output logic [3:0]          current_id,
	output logic                switched,
	output rrs_pkg::slot_cmd_t  slot_cmd,
	output logic [IDW-1:0]      slot_rel,
	input  rrs_pkg::slot_stat_t slot_stat,
	input  logic [IDW-1:0]      slot_idx
);
	import rrs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_HEAD = 4'd1;
	localparam logic [3:0] S_FIND = 4'd2;
	localparam logic [3:0] S_SRD  = 4'd3;
	localparam logic [3:0] S_SEV  = 4'd4;
	localparam logic [3:0] S_QNT  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_CUR  = 4'd7;

	function automatic logic [IDW-1:0] wrap(input logic [IDW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = (CW+1)'(a) + (CW+1)'(b);
		if (s >= (CW+1)'(MAX_TASKS))
			s = s - (CW+1)'(MAX_TASKS);
		return s[IDW-1:0];
	endfunction

	logic [3:0]     state_q, state_d;
	logic [1:0]     type_q;
	logic [15:0]    secs_q;
	logic           had_q;
	logic [IDW-1:0] old_q;
	logic [IDW-1:0] head_q;
	logic [CW-1:0]  cnt_q, sc_q, i_q, k_q;
	logic [15:0]    ql_q;
	logic [1:0]     status_q;
	logic [IDW-1:0] newid_q;

	logic [IDW-1:0] ring_mem [MAX_TASKS];
	logic [IDW-1:0] ring_rd_q, ring_ra, ring_wa, ring_wd;
	logic           ring_we;

	logic [IDW-1:0]    sid_mem [MAX_TASKS];
	logic [TICK_W-1:0] stk_mem [MAX_TASKS];
	logic [IDW-1:0]    sid_rd_q, slp_ra, slp_wa, slp_wid;
	logic [TICK_W-1:0] stk_rd_q, slp_wtk;
	logic              slp_we;

	logic [IDW-1:0] tail;
	logic [25:0]    prod;
	logic           now;
	logic [IDW-1:0] cur;
	logic           sw;

	assign tail = wrap(head_q, cnt_q);
	assign prod = 26'(secs_q) * 26'(ticks_per_second);
	assign now  = (cnt_q != '0);
	assign cur  = now ? ring_rd_q : '0;
	assign sw   = (had_q != now) || (had_q && now && (old_q != cur));

	always_comb begin
		state_d  = state_q;
		ring_ra  = head_q;
		ring_we  = 1'b0;
		ring_wa  = tail;
		ring_wd  = '0;
		slp_ra   = i_q[IDW-1:0];
		slp_we   = 1'b0;
		slp_wa   = sc_q[IDW-1:0];
		slp_wid  = ring_rd_q;
		slp_wtk  = TICK_W'(prod);
		slot_cmd = '0;
		slot_rel = ring_rd_q;
		case (state_q)
			S_IDLE: begin
				if (start)
					state_d = S_HEAD;
			end
			S_HEAD: begin
				state_d = S_FIN;
				case (type_q)
					REQ_CREATE: begin
						slot_cmd.scan_start = 1'b1;
						state_d = S_FIND;
					end
					REQ_TERM: begin
						slot_cmd.release_slot = now;
					end
					REQ_SLEEP: begin
						slp_we = now && (sc_q < CW'(MAX_TASKS));
					end
					default: begin
						state_d = S_SRD;
					end
				endcase
			end
			S_FIND: begin
				if (slot_stat.hit) begin
					slot_cmd.claim = 1'b1;
					ring_we = (cnt_q < CW'(MAX_TASKS));
					ring_wd = slot_idx;
					state_d = S_FIN;
				end else if (slot_stat.last) begin
					state_d = S_FIN;
				end else begin
					slot_cmd.scan_step = 1'b1;
				end
			end
			S_SRD: begin
				state_d = (i_q < sc_q) ? S_SEV : S_QNT;
			end
			S_SEV: begin
				if (stk_rd_q <= TICK_W'(1)) begin
					ring_we = (cnt_q < CW'(MAX_TASKS));
					ring_wd = sid_rd_q;
				end else begin
					slp_we  = 1'b1;
					slp_wa  = k_q[IDW-1:0];
					slp_wid = sid_rd_q;
					slp_wtk = stk_rd_q - TICK_W'(1);
				end
				state_d = S_SRD;
			end
			S_QNT: begin
				if (had_q && ql_q <= 16'd1) begin
					ring_we = 1'b1;
					ring_wd = old_q;
				end
				state_d = S_FIN;
			end
			S_FIN: begin
				state_d = S_CUR;
			end
			S_CUR: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		ring_rd_q <= ring_mem[ring_ra];
		if (ring_we)
			ring_mem[ring_wa] <= ring_wd;
	end

	always_ff @(posedge clk) begin
		sid_rd_q <= sid_mem[slp_ra];
		stk_rd_q <= stk_mem[slp_ra];
		if (slp_we) begin
			sid_mem[slp_wa] <= slp_wid;
			stk_mem[slp_wa] <= slp_wtk;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			type_q   <= REQ_TICK;
			secs_q   <= '0;
			had_q    <= 1'b0;
			old_q    <= '0;
			head_q   <= '0;
			cnt_q    <= '0;
			sc_q     <= '0;
			i_q      <= '0;
			k_q      <= '0;
			ql_q     <= QUANTUM_RST;
			status_q <= ST_OK;
			newid_q  <= '0;
		end else begin
			state_q <= state_d;
			if (ring_we && state_q != S_QNT && cnt_q < CW'(MAX_TASKS))
				cnt_q <= cnt_q + 1'b1;
			case (state_q)
				S_IDLE: begin
					if (start) begin
						type_q   <= req_type;
						secs_q   <= sleep_seconds;
						status_q <= ST_OK;
						newid_q  <= '0;
					end
				end
				S_HEAD: begin
					had_q <= now;
					old_q <= ring_rd_q;
					i_q   <= '0;
					k_q   <= '0;
					if (type_q == REQ_TERM || type_q == REQ_SLEEP) begin
						if (!now) begin
							status_q <= ST_NORUN;
						end else begin
							head_q <= wrap(head_q, CW'(1));
							cnt_q  <= cnt_q - 1'b1;
							if (type_q == REQ_SLEEP && sc_q < CW'(MAX_TASKS))
								sc_q <= sc_q + 1'b1;
						end
					end
				end
				S_FIND: begin
					if (slot_stat.hit)
						newid_q <= slot_idx;
					else if (slot_stat.last)
						status_q <= ST_NOFREE;
				end
				S_SEV: begin
					i_q <= i_q + 1'b1;
					if (stk_rd_q > TICK_W'(1))
						k_q <= k_q + 1'b1;
				end
				S_QNT: begin
					sc_q <= k_q;
					if (had_q) begin
						if (ql_q <= 16'd1) begin
							head_q <= wrap(head_q, CW'(1));
							ql_q   <= quantum_ticks;
						end else begin
							ql_q <= ql_q - 1'b1;
						end
					end
				end
				S_CUR: begin
					if (sw && now)
						ql_q <= quantum_ticks;
				end
				default: begin
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = (state_q == S_CUR);
	assign status        = status_q;
	assign new_id        = 4'(newid_q);
	assign current_valid = now;
	assign current_id    = 4'(cur);
	assign switched      = sw;

endmodule

### rtl/core/round_robin_scheduler_with_sleep.sv
// ----------------------------------------------------------------------------
// Round-robin scheduler with sleep timers
// Slot table, FIFO ready queue and sleeper countdowns behind a command port.
// ----------------------------------------------------------------------------
// channel | handshake           | payload
// request | start / busy        | req_type, sleep_seconds
// result  | done (one cycle)    | status, new_id, current_valid, current_id, switched
// config  | cfg_wr              | cfg_addr, cfg_data
//
// Create scans the slot table one slot per cycle, up to the first free slot or the last slot.
// Tick walks the sleeper list one entry at a time, then updates the quantum.
// Terminate and sleep need neither the slot scan nor the sleeper list walk.
// Reset clears control state at once; no clearing pass. Results cannot be stalled.
module round_robin_scheduler_with_sleep #(
	parameter int MAX_TASKS = rrs_pkg::MAX_TASKS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  req_type,
	input  logic [15:0] sleep_seconds,
	output logic        done,
	output logic [1:0]  status,
	output logic [3:0]  new_id,
	output logic        current_valid,
	output logic [3:0]  current_id,
	output logic        switched,
	input  logic        cfg_wr,
	input  logic        cfg_addr,
	input  logic [15:0] cfg_data
);
	import rrs_pkg::*;

	localparam int IDW = $clog2(MAX_TASKS);

	logic [15:0]    quantum_q;
	logic [9:0]     tps_q;
	slot_cmd_t      slot_cmd;
	slot_stat_t     slot_stat;
	logic [IDW-1:0] slot_rel, slot_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quantum_q <= QUANTUM_RST;
			tps_q     <= TPS_RST;
		end else if (cfg_wr) begin
			case (cfg_addr)
				REG_QUANTUM: quantum_q <= cfg_data;
				REG_TPS:     tps_q     <= cfg_data[9:0];
				default:     ;
			endcase
		end
	end

	rrs_slots #(.MAX_TASKS(MAX_TASKS)) u_slots (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (slot_cmd),
		.rel_id (slot_rel),
		.stat   (slot_stat),
		.idx    (slot_idx)
	);

	rrs_seq #(.MAX_TASKS(MAX_TASKS)) u_seq (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.req_type         (req_type),
		.sleep_seconds    (sleep_seconds),
		.quantum_ticks    (quantum_q),
		.ticks_per_second (tps_q),
		.busy             (busy),
		.done             (done),
		.status           (status),
		.new_id           (new_id),
		.current_valid    (current_valid),
		.current_id       (current_id),
		.switched         (switched),
		.slot_cmd         (slot_cmd),
		.slot_rel         (slot_rel),
		.slot_stat        (slot_stat),
		.slot_idx         (slot_idx)
	);

endmodule

### rtl/core/rrs_checker.sv
// ----------------------------------------------------------------------------
// Scheduler port checker
// Port-level checks on transaction sequencing and result consistency.
// ----------------------------------------------------------------------------
`include "round_robin_scheduler_with_sleep_macros.svh"

module rrs_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic       done,
	input logic [1:0] status,
	input logic [3:0] new_id,
	input logic       current_valid,
	input logic [3:0] current_id
);
	import rrs_pkg::*;

	`RRS_ASSERT_NXT(a_accept_busy, start && !busy, busy)
	`RRS_ASSERT_NXT(a_done_frees, done, !busy && !done)
	`RRS_ASSERT_IMP(a_done_in_busy, done, busy)
	`RRS_ASSERT_IMP(a_idle_id, done && !current_valid, current_id == 4'd0)
	`RRS_ASSERT_IMP(a_fail_id, done && status != ST_OK, new_id == 4'd0)

endmodule

bind round_robin_scheduler_with_sleep rrs_checker u_rrs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.done          (done),
	.status        (status),
	.new_id        (new_id),
	.current_valid (current_valid),
	.current_id    (current_id)
);
